// ===== hw/rtl/tha_pkg.sv =====
// shared types and constants of the typed handle allocator
`default_nettype none

package tha_pkg;

   // fixed field widths of the request and response words
   localparam int ACTION_W = 3;
   localparam int ID_W     = 9;
   localparam int TYPE_W   = 4;
   localparam int RESULT_W = 10;
   localparam int STATUS_W = 2;

   // request operation codes
   typedef enum logic [ACTION_W-1:0] {
      ACT_ACQUIRE  = 3'd0,
      ACT_RELEASE  = 3'd1,
      ACT_GET_PREV = 3'd2,
      ACT_GET_NEXT = 3'd3,
      ACT_FIRST    = 3'd4,
      ACT_CHECK    = 3'd5
   } action_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_BAD_ARG = 2'd1,
      ST_NO_FREE = 2'd2
   } status_type;

   // controller to datapath commands
   typedef struct packed {
      logic clr_step;
      logic accept;
      logic look;
      logic link;
      logic fin;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic is_move;
   } stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tha_if.sv =====
// request and response channel interfaces
`default_nettype none

interface tha_req_if;
   logic                          valid;
   logic                          ready;
   logic [tha_pkg::ACTION_W-1:0]  action;
   logic [tha_pkg::ID_W-1:0]      handle_id;
   logic [tha_pkg::TYPE_W-1:0]    handle_type;

   modport source (output valid, action, handle_id, handle_type, input ready);
   modport sink   (input valid, action, handle_id, handle_type, output ready);
endinterface

interface tha_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [tha_pkg::RESULT_W-1:0] result_id;
   logic                                type_match;
   logic [tha_pkg::STATUS_W-1:0]        status;

   modport source (output valid, result_id, type_match, status, input ready);
   modport sink   (input valid, result_id, type_match, status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tha_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module tha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tha_ctrl.sv =====
// controller state machine of the handle allocator
`default_nettype none

module tha_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire tha_pkg::stat_type stat,
   output tha_pkg::cmd_type       cmd
);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_LOOK  = 6'b000100,
      S_LINK  = 6'b001000,
      S_FIN   = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.look = 1'b1;
            state_in = stat.is_move ? S_LINK : S_RESP;
         end
         S_LINK: begin
            cmd.link = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/tha_dp.sv =====
// link tables, list heads and response registers of the handle allocator
`default_nettype none

module tha_dp #(
   parameter int HANDLES = 512,
   parameter int TYPES   = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire tha_pkg::cmd_type                    cmd,
   output tha_pkg::stat_type                        stat,
   input  wire logic [tha_pkg::ACTION_W-1:0]        req_action,
   input  wire logic [tha_pkg::ID_W-1:0]            req_handle_id,
   input  wire logic [tha_pkg::TYPE_W-1:0]          req_handle_type,
   output logic signed [tha_pkg::RESULT_W-1:0]      rsp_result_id,
   output logic                                     rsp_type_match,
   output logic [tha_pkg::STATUS_W-1:0]             rsp_status
);

   localparam int IW = $clog2(HANDLES);
   localparam int LW = IW + 1;
   localparam int TW = $clog2(TYPES);
   localparam int TPW = tha_pkg::TYPE_W;
   localparam logic [LW-1:0] NULL_LINK = {1'b1, {IW{1'b0}}};

   // link word: top bit marks no link
   function automatic logic signed [tha_pkg::RESULT_W-1:0] to_res(input logic [LW-1:0] l);
      return l[IW] ? '1 : tha_pkg::RESULT_W'(l[IW-1:0]);
   endfunction

   logic [IW-1:0]        clr_ff, clr_in;
   logic [LW-1:0]        head_ff [TYPES];
   logic [LW-1:0]        head_in [TYPES];
   tha_pkg::action_type  act_ff;
   logic [tha_pkg::ID_W-1:0] hid_ff;
   logic [TPW-1:0]       htype_ff;
   logic [IW-1:0]        mid_ff;
   logic signed [tha_pkg::RESULT_W-1:0] result_ff, result_in;
   logic                 match_ff, match_in;
   tha_pkg::status_type  status_ff, status_in;

   logic                 nx_we, pv_we, ty_we;
   logic [IW-1:0]        nx_wa, pv_wa, ty_wa, rd_addr;
   logic [LW-1:0]        nx_wd, pv_wd, nx_rd, pv_rd;
   logic [TPW-1:0]       ty_wd, ty_rd;

   logic                 id_ok, type_ok, free_ok, t_ok, unlink_head;
   logic [TPW-1:0]       new_type;
   logic [LW-1:0]        h_link;
   logic [TW-1:0]        t_ix, new_ix;

   // request decode
   assign id_ok    = 32'(hid_ff) < HANDLES;
   assign type_ok  = 32'(htype_ff) < TYPES;
   assign free_ok  = !head_ff[0][IW];
   assign new_type = (act_ff == tha_pkg::ACT_ACQUIRE) ? htype_ff : '0;
   assign new_ix   = TW'(new_type);
   assign t_ok     = 32'(ty_rd) < TYPES;
   assign t_ix     = TW'(ty_rd);
   assign h_link   = head_ff[new_ix];
   assign unlink_head = cmd.look && stat.is_move && pv_rd[IW] && t_ok &&
                        (head_ff[t_ix] == {1'b0, mid_ff});

   assign stat.is_move =
      ((act_ff == tha_pkg::ACT_ACQUIRE) && (htype_ff != '0) && type_ok && free_ok) ||
      ((act_ff == tha_pkg::ACT_RELEASE) && id_ok);
   assign stat.clear_last = (clr_ff == IW'(HANDLES - 1));
   assign clr_in = clr_ff + IW'(1);

   // read address: the free head for acquire, else the named handle
   assign rd_addr = (tha_pkg::action_type'(req_action) == tha_pkg::ACT_ACQUIRE) ?
                    head_ff[0][IW-1:0] : IW'(req_handle_id);

   // next link table writes
   always_comb begin
      nx_we = 1'b0;
      nx_wa = mid_ff;
      nx_wd = h_link;
      if (cmd.clr_step) begin
         nx_we = 1'b1;
         nx_wa = clr_ff;
         nx_wd = stat.clear_last ? NULL_LINK : {1'b0, clr_in};
      end else if (cmd.look && stat.is_move && !pv_rd[IW]) begin
         nx_we = 1'b1;
         nx_wa = pv_rd[IW-1:0];
         nx_wd = nx_rd;
      end else if (cmd.link) begin
         nx_we = 1'b1;
      end
   end

   // previous link table writes
   always_comb begin
      pv_we = 1'b0;
      pv_wa = mid_ff;
      pv_wd = NULL_LINK;
      if (cmd.clr_step) begin
         pv_we = 1'b1;
         pv_wa = clr_ff;
         pv_wd = (clr_ff == '0) ? NULL_LINK : {1'b0, clr_ff - IW'(1)};
      end else if (cmd.look && stat.is_move && !nx_rd[IW]) begin
         pv_we = 1'b1;
         pv_wa = nx_rd[IW-1:0];
         pv_wd = pv_rd;
      end else if (cmd.link && !h_link[IW]) begin
         pv_we = 1'b1;
         pv_wa = h_link[IW-1:0];
         pv_wd = {1'b0, mid_ff};
      end else if (cmd.fin) begin
         pv_we = 1'b1;
      end
   end

   // type table writes
   assign ty_we = cmd.clr_step || (cmd.look && stat.is_move);
   assign ty_wa = cmd.clr_step ? clr_ff : mid_ff;
   assign ty_wd = cmd.clr_step ? '0 : new_type;

   tha_ram #(.WIDTH(LW), .DEPTH(HANDLES)) u_next (
      .clock(clock), .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
      .rd_en(cmd.accept), .rd_addr(rd_addr), .rd_data(nx_rd)
   );

   tha_ram #(.WIDTH(LW), .DEPTH(HANDLES)) u_prev (
      .clock(clock), .wr_en(pv_we), .wr_addr(pv_wa), .wr_data(pv_wd),
      .rd_en(cmd.accept), .rd_addr(rd_addr), .rd_data(pv_rd)
   );

   tha_ram #(.WIDTH(TPW), .DEPTH(HANDLES)) u_type (
      .clock(clock), .wr_en(ty_we), .wr_addr(ty_wa), .wr_data(ty_wd),
      .rd_en(cmd.accept), .rd_addr(rd_addr), .rd_data(ty_rd)
   );

   // list head updates: unlink during lookup, push at link step
   always_comb begin
      for (int i = 0; i < TYPES; i++) begin
         head_in[i] = head_ff[i];
      end
      if (unlink_head) head_in[t_ix] = nx_rd;
      if (cmd.link) head_in[new_ix] = {1'b0, mid_ff};
   end

   // response word
   always_comb begin
      result_in = '1;
      match_in  = 1'b0;
      status_in = tha_pkg::ST_OK;
      unique case (act_ff)
         tha_pkg::ACT_ACQUIRE: begin
            if (htype_ff == '0 || !type_ok) status_in = tha_pkg::ST_BAD_ARG;
            else if (!free_ok)              status_in = tha_pkg::ST_NO_FREE;
            else                            result_in = to_res(head_ff[0]);
         end
         tha_pkg::ACT_RELEASE: begin
            if (!id_ok) status_in = tha_pkg::ST_BAD_ARG;
         end
         tha_pkg::ACT_GET_PREV: begin
            if (id_ok) result_in = to_res(pv_rd);
            else       status_in = tha_pkg::ST_BAD_ARG;
         end
         tha_pkg::ACT_GET_NEXT: begin
            if (id_ok) result_in = to_res(nx_rd);
            else       status_in = tha_pkg::ST_BAD_ARG;
         end
         tha_pkg::ACT_FIRST: begin
            if (type_ok) result_in = to_res(head_ff[TW'(htype_ff)]);
            else         status_in = tha_pkg::ST_BAD_ARG;
         end
         tha_pkg::ACT_CHECK: begin
            if (id_ok && type_ok) match_in  = (ty_rd == htype_ff);
            else                  status_in = tha_pkg::ST_BAD_ARG;
         end
         default: status_in = tha_pkg::ST_BAD_ARG;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         for (int i = 0; i < TYPES; i++) begin
            head_ff[i] <= (i == 0) ? '0 : NULL_LINK;
         end
      end else begin
         if (cmd.clr_step) clr_ff <= clr_in;
         for (int i = 0; i < TYPES; i++) begin
            head_ff[i] <= head_in[i];
         end
      end
   end

   // request and response payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff   <= tha_pkg::action_type'(req_action);
         hid_ff   <= req_handle_id;
         htype_ff <= req_handle_type;
         mid_ff   <= rd_addr;
      end
      if (cmd.look) begin
         result_ff <= result_in;
         match_ff  <= match_in;
         status_ff <= status_in;
      end
   end

   assign rsp_result_id  = result_ff;
   assign rsp_type_match = match_ff;
   assign rsp_status     = status_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/typed_handle_allocator_unit.sv =====
// top level of the typed handle allocator
//
// Keeps HANDLES handles on doubly linked lists, one list per type, type 0
// being the free list. The req_ch channel takes one word per operation
// (acquire, release, previous or next link, first of type, type check);
// the rsp_ch channel returns exactly one word for each.
// After reset the block runs a clearing pass over the link and type
// tables, with req_ch.ready low, that chains all handles in ascending
// order on the free list.
// A query word is looked up once taken, its response is registered and
// then shown on rsp_ch; acquire and release also pass a link and a fin
// step, since the unlink and relink writes go through the single write
// port of each link table.
// A response is held stable while rsp_ch.ready is low; no new word is
// taken until the pending response has been delivered.
`default_nettype none

module typed_handle_allocator_unit #(
   parameter int HANDLES = 512,
   parameter int TYPES   = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tha_req_if.sink    req_ch,
   tha_rsp_if.source  rsp_ch
);

   tha_pkg::cmd_type  cmd;
   tha_pkg::stat_type stat;
   logic              req_ready;
   logic              rsp_valid;

   // sequencing
   tha_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ch.ready),
      .stat(stat), .cmd(cmd)
   );

   // tables and response word
   tha_dp #(.HANDLES(HANDLES), .TYPES(TYPES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_action(req_ch.action), .req_handle_id(req_ch.handle_id),
      .req_handle_type(req_ch.handle_type),
      .rsp_result_id(rsp_ch.result_id), .rsp_type_match(rsp_ch.type_match),
      .rsp_status(rsp_ch.status)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

   // never take a word while a response is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while response pending");

   // a taken word is looked up in the next cycle
   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> cmd.look) else $error("lookup missing after accept");

   // a query responds right after its lookup
   a_query_rsp: assert property (@(posedge clock) disable iff (reset)
      (cmd.look && !stat.is_move) |=> rsp_valid) else $error("query response late");

   // relink follows every move
   a_move_seq: assert property (@(posedge clock) disable iff (reset)
      (cmd.look && stat.is_move) |=> cmd.link ##1 cmd.fin) else $error("relink skipped");

endmodule

`default_nettype wire
